@@ hw/rtl/shcd_pkg.sv @@
// ----------------------------------------------------------------------------
// shcd_pkg: shared types and constants of the switch click/hold detector
// Event codes, channel codes, register indexes and the per-button sample
// function used by the front end.
// ----------------------------------------------------------------------------
`default_nettype none

package shcd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int NUM_SRC    = 3;

    localparam logic [15:0] SAMPLE_PERIOD_RST   = 16'd20;
    localparam logic [7:0]  HOLD_THRESHOLD_RST  = 8'd18;
    localparam logic [7:0]  CLICK_THRESHOLD_RST = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_PERIOD   = 2'd0,
        REG_HOLD_THRESHOLD  = 2'd1,
        REG_CLICK_THRESHOLD = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        EV_OFF      = 3'd0,
        EV_ON       = 3'd1,
        EV_CLICK    = 3'd2,
        EV_HOLD     = 3'd3,
        EV_HOLD_END = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        CH_MAIN    = 2'd0,
        CH_BUTTON0 = 2'd1,
        CH_BUTTON1 = 2'd2
    } t_channel;

    // Events of one poll: one slot per source, slot index equals channel code.
    typedef struct packed {
        logic [NUM_SRC-1:0]        mask;
        logic [NUM_SRC-1:0][2:0]   code;
    } t_bundle;

    typedef struct packed {
        logic [7:0] count;
        logic       held;
        logic       ev_vld;
        logic [2:0] ev;
    } t_btn_res;

    function automatic t_btn_res sample_btn(
        input logic       pressed,
        input logic [7:0] cnt,
        input logic       was_held,
        input logic [7:0] hold_thr,
        input logic [7:0] click_thr
    );
        t_btn_res   res;
        logic [7:0] c;
        logic       h;
        logic       clicked;
        c       = cnt;
        h       = 1'b0;
        clicked = 1'b0;
        if (pressed) begin
            if (c != 8'hFF) begin
                c = c + 8'd1;
            end
            if (c > hold_thr) begin
                h = 1'b1;
                c = hold_thr;
            end
        end else begin
            if ((c > click_thr) && (c < hold_thr) && !was_held) begin
                clicked = 1'b1;
            end
            c = 8'd0;
        end
        res.count  = c;
        res.held   = h;
        res.ev_vld = clicked | h | was_held;
        if (clicked) begin
            res.ev = EV_CLICK;
        end else if (h) begin
            res.ev = EV_HOLD;
        end else begin
            res.ev = EV_HOLD_END;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/shcd_if.sv @@
// ----------------------------------------------------------------------------
// shcd_if: channel interfaces of the switch click/hold detector
// Poll channel, event channel and configuration write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface shcd_in_if;
    logic valid;
    logic ready;
    logic main_level;
    logic button0_pressed;
    logic button1_pressed;
    logic tick;

    modport source (output valid, main_level, button0_pressed, button1_pressed, tick,
                    input ready);
    modport sink (input valid, main_level, button0_pressed, button1_pressed, tick,
                  output ready);
endinterface

interface shcd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [1:0] channel;
    logic       last;

    modport source (output valid, event_res, channel, last, input ready);
    modport sink (input valid, event_res, channel, last, output ready);
endinterface

interface shcd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [shcd_pkg::CFG_IDX_W-1:0]  index;
    logic [shcd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/shcd_front.sv @@
// ----------------------------------------------------------------------------
// shcd_front: poll classifier
// Holds configuration and detector state, takes one poll per cycle while the
// event queue has room and pushes the events it causes into it as one bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module shcd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    shcd_in_if.sink           i_in,
    shcd_cfg_if.sink          i_cfg,
    input  wire               i_full,
    output logic              o_push,
    output shcd_pkg::t_bundle o_bundle
);

    logic [15:0] r_sample_period;
    logic [7:0]  r_hold_thr;
    logic [7:0]  r_click_thr;
    logic        r_main;
    logic [15:0] r_tick_count;
    logic [1:0][7:0] r_press_count;
    logic [1:0]  r_was_held;

    logic        n_main;
    logic [15:0] n_tick_count;
    logic [1:0][7:0] n_press_count;
    logic [1:0]  n_was_held;

    logic        accept;
    logic [15:0] tick_inc;
    logic        sample;
    logic        main_chg;
    shcd_pkg::t_btn_res btn_res [2];
    shcd_pkg::t_bundle  bundle;

    assign i_in.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && !i_full;

    always_comb begin
        main_chg = i_in.main_level != r_main;
        if (i_in.tick && (r_tick_count != 16'hFFFF)) begin
            tick_inc = r_tick_count + 16'd1;
        end else begin
            tick_inc = r_tick_count;
        end
        sample     = tick_inc >= r_sample_period;
        btn_res[0] = shcd_pkg::sample_btn(i_in.button0_pressed, r_press_count[0],
                                          r_was_held[0], r_hold_thr, r_click_thr);
        btn_res[1] = shcd_pkg::sample_btn(i_in.button1_pressed, r_press_count[1],
                                          r_was_held[1], r_hold_thr, r_click_thr);

        bundle.mask[0] = main_chg;
        bundle.code[0] = i_in.main_level ? shcd_pkg::EV_ON : shcd_pkg::EV_OFF;
        bundle.mask[1] = sample && btn_res[0].ev_vld;
        bundle.code[1] = btn_res[0].ev;
        bundle.mask[2] = sample && btn_res[1].ev_vld;
        bundle.code[2] = btn_res[1].ev;

        n_main        = r_main;
        n_tick_count  = r_tick_count;
        n_press_count = r_press_count;
        n_was_held    = r_was_held;
        if (accept) begin
            n_main       = i_in.main_level;
            n_tick_count = sample ? 16'd0 : tick_inc;
            if (sample) begin
                n_press_count[0] = btn_res[0].count;
                n_press_count[1] = btn_res[1].count;
                n_was_held[0]    = btn_res[0].held;
                n_was_held[1]    = btn_res[1].held;
            end
        end
    end

    // A poll that causes no event leaves nothing in the queue.
    assign o_push   = accept && (bundle.mask != '0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= shcd_pkg::SAMPLE_PERIOD_RST;
            r_hold_thr      <= shcd_pkg::HOLD_THRESHOLD_RST;
            r_click_thr     <= shcd_pkg::CLICK_THRESHOLD_RST;
            r_main          <= 1'b0;
            r_tick_count    <= '0;
            r_press_count   <= '0;
            r_was_held      <= '0;
        end else begin
            r_main        <= n_main;
            r_tick_count  <= n_tick_count;
            r_press_count <= n_press_count;
            r_was_held    <= n_was_held;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    shcd_pkg::REG_SAMPLE_PERIOD:   r_sample_period <= i_cfg.data;
                    shcd_pkg::REG_HOLD_THRESHOLD:  r_hold_thr      <= i_cfg.data[7:0];
                    shcd_pkg::REG_CLICK_THRESHOLD: r_click_thr     <= i_cfg.data[7:0];
                    default: ;
                endcase
            end
        end
    end

    a_sample_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && sample |=> r_tick_count == 16'd0)
        else $error("tick count did not restart after a button sample");

    a_main_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && bundle.mask[0] |=> r_main == $past(i_in.main_level))
        else $error("main switch state not updated with its event");

endmodule

`default_nettype wire

@@ hw/rtl/shcd_fifo.sv @@
// ----------------------------------------------------------------------------
// shcd_fifo: event bundle queue
// Short first-in first-out queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module shcd_fifo #(
    parameter int DEPTH = shcd_pkg::FIFO_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  shcd_pkg::t_bundle i_data,
    input  wire               i_pop,
    output shcd_pkg::t_bundle o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    shcd_pkg::t_bundle r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full event queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty event queue");

endmodule

`default_nettype wire

@@ hw/rtl/shcd_back.sv @@
// ----------------------------------------------------------------------------
// shcd_back: event emitter
// Takes bundles from the queue and sends their events one per cycle, while
// the receiver is ready, through a registered output stage, marking the final
// event of each poll.
`default_nettype none

module shcd_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  shcd_pkg::t_bundle i_bundle,
    input  wire               i_empty,
    output logic              o_pop,
    shcd_out_if.source        o_out
);

    logic [shcd_pkg::NUM_SRC-1:0]      r_mask;
    logic [shcd_pkg::NUM_SRC-1:0][2:0] r_code;
    logic       r_out_valid;
    logic [2:0] r_out_event;
    logic [1:0] r_out_channel;
    logic       r_out_last;

    logic [shcd_pkg::NUM_SRC-1:0] pick;
    logic [shcd_pkg::NUM_SRC-1:0] mask_after;
    logic [1:0] sel;
    logic       out_free;
    logic       adv;

    always_comb begin
        pick       = r_mask & (~r_mask + 1'b1);
        mask_after = r_mask & ~pick;
        if (r_mask[0]) begin
            sel = shcd_pkg::CH_MAIN;
        end else if (r_mask[1]) begin
            sel = shcd_pkg::CH_BUTTON0;
        end else begin
            sel = shcd_pkg::CH_BUTTON1;
        end
        out_free = !r_out_valid || o_out.ready;
        adv      = (r_mask != '0) && out_free;
        // Refill as soon as the current bundle is used up, in the same cycle
        // as its final event moves to the output stage.
        o_pop    = !i_empty && ((r_mask == '0) || (adv && (mask_after == '0)));
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code <= i_bundle.code;
        end
        if (adv) begin
            r_out_event   <= r_code[sel];
            r_out_channel <= sel;
            r_out_last    <= mask_after == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mask <= i_bundle.mask;
            end else if (adv) begin
                r_mask <= mask_after;
            end
            if (out_free) begin
                r_out_valid <= adv;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_event;
    assign o_out.channel   = r_out_channel;
    assign o_out.last      = r_out_last;

    a_refill_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_mask != '0)
        else $error("empty bundle taken from the event queue");

    a_main_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_channel == shcd_pkg::CH_MAIN) |->
            (r_out_event == shcd_pkg::EV_OFF) || (r_out_event == shcd_pkg::EV_ON))
        else $error("main switch channel carries a button event");

endmodule

`default_nettype wire

@@ hw/rtl/switch_click_hold_detector_top.sv @@
// ----------------------------------------------------------------------------
// switch_click_hold_detector_top: main switch and two-button click/hold detector
// Usage:
//   i_in  takes one poll per request: main switch level, two button levels
//         and a timer-tick flag. It is ready whenever the event queue has room,
//         so polls are normally taken every cycle.
//   o_out gives one event per request: event code, channel and a flag on the
//         final event of a poll. A poll causes zero to three events.
//   i_cfg writes sample period, hold and click threshold and is always ready;
//         the user must write it only while the block is idle; not enforced.
// Path: a poll's events pass the event queue, the emitter's bundle register
//   and the output register. Throughput: one event per cycle at the output
//   register while the receiver is ready, taking a poll's events in turn.
// Reset (synchronous, active low) restores the register defaults, sets the
//   switch state to off and clears tick count, press counts and hold flags.
// When the receiver stalls, the output holds; the queue of FIFO_DEPTH event
//   bundles absorbs polls until it fills, then i_in deasserts ready.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_click_hold_detector_top #(
    parameter int FIFO_DEPTH = shcd_pkg::FIFO_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    shcd_in_if.sink    i_in,
    shcd_cfg_if.sink   i_cfg,
    shcd_out_if.source o_out
);

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    shcd_pkg::t_bundle push_data;
    shcd_pkg::t_bundle pop_data;

    shcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_data)
    );

    shcd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_full  (full),
        .o_empty (empty)
    );

    shcd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bundle (pop_data),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the switch click/hold detector
// A short table of directed polls and register writes is walked first, then
// several randomized phases with different sample periods and thresholds.
// Every accepted poll is run through a local model of the detector, and each
// event taken from the output is compared with the oldest pending event.
// ----------------------------------------------------------------------------

module tb;

    localparam logic [shcd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 40;

    typedef struct {
        shcd_pkg::t_event   ev;
        shcd_pkg::t_channel ch;
        logic               last;
    } t_event_rec;

    // One line of directed stimulus: a register write or a poll. A poll with
    // n_typed >= 0 carries its events written out by hand.
    typedef struct {
        logic                            is_cfg;
        logic [shcd_pkg::CFG_IDX_W-1:0]  idx;
        logic [shcd_pkg::CFG_DATA_W-1:0] data;
        logic                            lvl;
        logic                            b0;
        logic                            b1;
        logic                            tk;
        int                              n_typed;
        shcd_pkg::t_event                tev[3];
        shcd_pkg::t_channel              tch[3];
    } t_stim_row;

    typedef struct {
        int unsigned period;
        int unsigned hold;
        int unsigned click;
        int          n_polls;
        int          tick_pct;
        bit          long_b0;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    shcd_in_if  poll_if ();
    shcd_cfg_if cfg_if ();
    shcd_out_if ev_if ();

    switch_click_hold_detector_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (poll_if),
        .i_cfg   (cfg_if),
        .o_out   (ev_if)
    );

    always #6 i_clk = ~i_clk;

    // Detector state as the model keeps it.
    logic [15:0] cfg_period;
    logic [7:0]  cfg_hold;
    logic [7:0]  cfg_click;
    logic        sw_on;
    int unsigned tick_cnt;
    logic [7:0]  press_cnt[2];
    logic        in_hold[2];

    t_event_rec  pending_events[$];
    int          mismatches = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;

    t_stim_row   dir_rows[$];
    t_phase      phases[$];

    function automatic int draw_gap(input bit on);
        return on ? $urandom_range(11, 0) : 0;
    endfunction

    function automatic void apply_reg(input logic [shcd_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [shcd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            shcd_pkg::REG_SAMPLE_PERIOD:   cfg_period = data;
            shcd_pkg::REG_HOLD_THRESHOLD:  cfg_hold   = data[7:0];
            shcd_pkg::REG_CLICK_THRESHOLD: cfg_click  = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void predict_poll(input logic lvl, input logic b0, input logic b1,
                                         input logic tk, output t_event_rec evs[3],
                                         output int n);
        int                 b;
        int unsigned        c;
        logic               pressed;
        logic               held;
        logic               clicked;
        shcd_pkg::t_channel ch;
        n = 0;
        if (lvl != sw_on) begin
            sw_on  = lvl;
            evs[n] = '{ev: (lvl ? shcd_pkg::EV_ON : shcd_pkg::EV_OFF),
                       ch: shcd_pkg::CH_MAIN, last: 1'b0};
            n++;
        end
        if (tk && tick_cnt < 32'hFFFF) begin
            tick_cnt++;
        end
        // The sample test runs on every poll, tick or not.
        if (tick_cnt >= cfg_period) begin
            tick_cnt = 0;
            for (b = 0; b < 2; b++) begin
                pressed = (b == 0) ? b0 : b1;
                ch      = (b == 0) ? shcd_pkg::CH_BUTTON0 : shcd_pkg::CH_BUTTON1;
                c       = press_cnt[b];
                held    = 1'b0;
                clicked = 1'b0;
                if (pressed) begin
                    if (c < 255) begin
                        c++;
                    end
                    if (c > cfg_hold) begin
                        held = 1'b1;
                        c    = cfg_hold;
                    end
                end else begin
                    if (c > cfg_click && c < cfg_hold && !in_hold[b]) begin
                        clicked = 1'b1;
                    end
                    c = 0;
                end
                press_cnt[b] = c[7:0];
                if (clicked) begin
                    evs[n] = '{ev: shcd_pkg::EV_CLICK, ch: ch, last: 1'b0};
                    n++;
                end else if (held) begin
                    evs[n] = '{ev: shcd_pkg::EV_HOLD, ch: ch, last: 1'b0};
                    n++;
                end else if (in_hold[b]) begin
                    evs[n] = '{ev: shcd_pkg::EV_HOLD_END, ch: ch, last: 1'b0};
                    n++;
                end
                in_hold[b] = held;
            end
        end
        if (n > 0) begin
            evs[n-1].last = 1'b1;
        end
    endfunction

    function automatic t_stim_row cfg_row(input logic [shcd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [shcd_pkg::CFG_DATA_W-1:0] data);
        t_stim_row r;
        r         = '{default: '0, tev: '{default: shcd_pkg::EV_OFF},
                      tch: '{default: shcd_pkg::CH_MAIN}};
        r.is_cfg  = 1'b1;
        r.idx     = idx;
        r.data    = data;
        r.n_typed = -1;
        return r;
    endfunction

    function automatic t_stim_row poll_row(input logic lvl, input logic b0, input logic b1,
                                           input logic tk, input int n = -1,
                                           input shcd_pkg::t_event e0 = shcd_pkg::EV_OFF,
                                           input shcd_pkg::t_channel c0 = shcd_pkg::CH_MAIN,
                                           input shcd_pkg::t_event e1 = shcd_pkg::EV_OFF,
                                           input shcd_pkg::t_channel c1 = shcd_pkg::CH_MAIN,
                                           input shcd_pkg::t_event e2 = shcd_pkg::EV_OFF,
                                           input shcd_pkg::t_channel c2 = shcd_pkg::CH_MAIN);
        t_stim_row r;
        r         = '{default: '0, tev: '{default: shcd_pkg::EV_OFF},
                      tch: '{default: shcd_pkg::CH_MAIN}};
        r.lvl     = lvl;
        r.b0      = b0;
        r.b1      = b1;
        r.tk      = tk;
        r.n_typed = n;
        r.tev     = '{e0, e1, e2};
        r.tch     = '{c0, c1, c2};
        return r;
    endfunction

    // Lower the poll valid and wait until the block has nothing left in flight.
    task automatic wait_idle();
        poll_if.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [shcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [shcd_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg(idx, data);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_poll(input t_stim_row r);
        int         gap;
        bit         pause;
        int         n;
        int         k;
        t_event_rec evs[3];
        gap   = draw_gap(tx_gaps_on);
        pause = ($urandom_range(24, 0) == 0);
        if (gap > 0 || pause) begin
            poll_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (pause) begin
                do @(posedge i_clk); while (pending_events.size() != 0);
            end
        end
        poll_if.valid           <= 1'b1;
        poll_if.main_level      <= r.lvl;
        poll_if.button0_pressed <= r.b0;
        poll_if.button1_pressed <= r.b1;
        poll_if.tick            <= r.tk;
        do @(posedge i_clk); while (!poll_if.ready);
        predict_poll(r.lvl, r.b0, r.b1, r.tk, evs, n);
        if (r.n_typed >= 0) begin
            n = r.n_typed;
            for (k = 0; k < n; k++) begin
                evs[k] = '{ev: r.tev[k], ch: r.tch[k], last: (k == n - 1)};
            end
        end
        for (k = 0; k < n; k++) begin
            pending_events.push_back(evs[k]);
        end
    endtask

    // Event receiver: random stalls, compare against the oldest pending event.
    initial begin
        int         stall;
        t_event_rec want;
        ev_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_gap(rx_gaps_on);
            if (stall > 0) begin
                ev_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            ev_if.ready <= 1'b1;
            do @(posedge i_clk); while (!ev_if.valid);
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected event: expected none, got ev=%0d ch=%0d last=%0d",
                             $time, ev_if.event_res, ev_if.channel, ev_if.last);
                end
            end else begin
                want = pending_events.pop_front();
                if (ev_if.event_res !== want.ev) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: event code: expected %0d, got %0d",
                                 $time, want.ev, ev_if.event_res);
                    end
                end
                if (ev_if.channel !== want.ch) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: channel: expected %0d, got %0d",
                                 $time, want.ch, ev_if.channel);
                    end
                end
                if (ev_if.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: last flag: expected %0d, got %0d",
                                 $time, want.last, ev_if.last);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          i;
        int          p;
        int          j;
        int          b;
        int          max_run;
        int          run_left[2];
        logic        btn_lvl[2];
        logic        btn[2];
        logic        lvl;
        logic        tk;
        t_phase      ph;

        i_rst_n                 <= 1'b0;
        poll_if.valid           <= 1'b0;
        poll_if.main_level      <= 1'b0;
        poll_if.button0_pressed <= 1'b0;
        poll_if.button1_pressed <= 1'b0;
        poll_if.tick            <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.index            <= shcd_pkg::REG_SAMPLE_PERIOD;
        cfg_if.data             <= '0;

        cfg_period   = shcd_pkg::SAMPLE_PERIOD_RST;
        cfg_hold     = shcd_pkg::HOLD_THRESHOLD_RST;
        cfg_click    = shcd_pkg::CLICK_THRESHOLD_RST;
        sw_on        = 1'b0;
        tick_cnt     = 0;
        press_cnt[0] = '0;
        press_cnt[1] = '0;
        in_hold[0]   = 1'b0;
        in_hold[1]   = 1'b0;

        // Directed part. Reset values: period 20, hold 18, click 0.
        dir_rows.push_back(poll_row(1, 0, 0, 0, 1, shcd_pkg::EV_ON, shcd_pkg::CH_MAIN));
        dir_rows.push_back(poll_row(0, 0, 0, 1, 1, shcd_pkg::EV_OFF, shcd_pkg::CH_MAIN));
        dir_rows.push_back(poll_row(0, 0, 0, 0, 0));
        // A zero period samples the buttons on every poll.
        dir_rows.push_back(cfg_row(shcd_pkg::REG_SAMPLE_PERIOD, 16'd0));
        dir_rows.push_back(poll_row(0, 1, 0, 0, 0));
        dir_rows.push_back(poll_row(0, 0, 0, 0, 1, shcd_pkg::EV_CLICK, shcd_pkg::CH_BUTTON0));
        // With a zero hold threshold every sampled press is a hold.
        dir_rows.push_back(cfg_row(shcd_pkg::REG_HOLD_THRESHOLD, 16'd0));
        dir_rows.push_back(poll_row(1, 1, 1, 1, 3, shcd_pkg::EV_ON, shcd_pkg::CH_MAIN,
                                    shcd_pkg::EV_HOLD, shcd_pkg::CH_BUTTON0,
                                    shcd_pkg::EV_HOLD, shcd_pkg::CH_BUTTON1));
        dir_rows.push_back(poll_row(0, 0, 0, 0, 3, shcd_pkg::EV_OFF, shcd_pkg::CH_MAIN,
                                    shcd_pkg::EV_HOLD_END, shcd_pkg::CH_BUTTON0,
                                    shcd_pkg::EV_HOLD_END, shcd_pkg::CH_BUTTON1));
        // Upper data bits are dropped for the 8-bit thresholds.
        dir_rows.push_back(cfg_row(shcd_pkg::REG_HOLD_THRESHOLD, 16'hFF02));
        dir_rows.push_back(poll_row(0, 1, 0, 0));
        dir_rows.push_back(poll_row(0, 1, 0, 1));
        dir_rows.push_back(poll_row(0, 1, 0, 0));
        // Raising the hold threshold during a hold must not turn the release
        // into a click.
        dir_rows.push_back(cfg_row(shcd_pkg::REG_HOLD_THRESHOLD, 16'd200));
        dir_rows.push_back(poll_row(0, 0, 0, 0, 1, shcd_pkg::EV_HOLD_END,
                                    shcd_pkg::CH_BUTTON0));
        // Click threshold just below the hold threshold: short presses stay silent.
        dir_rows.push_back(cfg_row(shcd_pkg::REG_HOLD_THRESHOLD, 16'd254));
        dir_rows.push_back(cfg_row(shcd_pkg::REG_CLICK_THRESHOLD, 16'd253));
        dir_rows.push_back(poll_row(0, 0, 1, 1));
        dir_rows.push_back(poll_row(0, 0, 1, 0));
        dir_rows.push_back(poll_row(0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(shcd_pkg::REG_CLICK_THRESHOLD, 16'hFFFF));
        dir_rows.push_back(cfg_row(REG_UNUSED, 16'h0001));
        // Lowering the period below the tick count samples without a tick.
        dir_rows.push_back(cfg_row(shcd_pkg::REG_SAMPLE_PERIOD, 16'hFFFF));
        dir_rows.push_back(poll_row(1, 0, 0, 1));
        dir_rows.push_back(poll_row(1, 0, 0, 1));
        dir_rows.push_back(cfg_row(shcd_pkg::REG_SAMPLE_PERIOD, 16'd1));
        dir_rows.push_back(poll_row(1, 1, 0, 0));
        dir_rows.push_back(cfg_row(shcd_pkg::REG_CLICK_THRESHOLD, 16'd0));
        dir_rows.push_back(poll_row(0, 0, 1, 1));
        dir_rows.push_back(poll_row(0, 0, 0, 1));

        phases.push_back('{period: 1, hold: 4, click: 1, n_polls: 50, tick_pct: 75, long_b0: 0});
        phases.push_back('{period: 0, hold: 6, click: 0, n_polls: 50, tick_pct: 50, long_b0: 0});
        phases.push_back('{period: 3, hold: 2, click: 0, n_polls: 40, tick_pct: 90, long_b0: 0});
        phases.push_back('{period: 20, hold: 18, click: 0, n_polls: 60, tick_pct: 100,
                           long_b0: 0});
        phases.push_back('{period: 0, hold: 1, click: 0, n_polls: 40, tick_pct: 50, long_b0: 0});
        phases.push_back('{period: 2, hold: 10, click: 5, n_polls: 50, tick_pct: 80,
                           long_b0: 0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].is_cfg) begin
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_poll(dir_rows[i]);
            end
        end

        lvl = sw_on;
        for (p = 0; p < phases.size(); p++) begin
            ph = phases[p];
            write_reg(shcd_pkg::REG_SAMPLE_PERIOD, ph.period[15:0]);
            write_reg(shcd_pkg::REG_HOLD_THRESHOLD, ph.hold[15:0]);
            write_reg(shcd_pkg::REG_CLICK_THRESHOLD, ph.click[15:0]);
            tx_gaps_on = ($urandom_range(3, 0) != 0);
            rx_gaps_on = ($urandom_range(3, 0) != 0);
            // Presses run a little longer than a hold takes to build up.
            max_run = (ph.hold + 3) * (ph.period + 1);
            if (max_run > 60) begin
                max_run = 60;
            end
            run_left = '{0, 0};
            btn_lvl  = '{1'b0, 1'b0};
            for (j = 0; j < ph.n_polls; j++) begin
                for (b = 0; b < 2; b++) begin
                    if (run_left[b] == 0) begin
                        btn_lvl[b]  = $urandom_range(1, 0);
                        run_left[b] = $urandom_range(max_run, 1);
                    end
                    run_left[b]--;
                    btn[b] = btn_lvl[b];
                    // Occasional single-poll glitch breaks up a press or release.
                    if ($urandom_range(9, 0) == 0) begin
                        btn[b] = ~btn[b];
                    end
                end
                if (ph.long_b0) begin
                    btn[0] = (j != ph.n_polls - 1);
                end
                if ($urandom_range(4, 0) == 0) begin
                    lvl = ~lvl;
                end
                tk = ($urandom_range(100, 1) <= ph.tick_pct);
                send_poll(poll_row(lvl, btn[0], btn[1], tk));
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/shcd_pkg.sv
hw/rtl/shcd_if.sv
hw/rtl/shcd_front.sv
hw/rtl/shcd_fifo.sv
hw/rtl/shcd_back.sv
hw/rtl/switch_click_hold_detector_top.sv
tb/tb.sv
